[src/dstq_pkg.sv]
// Shared types and constants for the deadline-sorted timer queue.
// No dependencies; used by dstq_cell and deadline_sorted_timer_queue_core.
package dstq_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int RESULT_CAP  = 16;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int HITS_W      = $clog2(RESULT_CAP + 1);

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_REMOVE_ONE = 3'd1,
        OP_REMOVE_ALL = 3'd2,
        OP_FIND_ONE   = 3'd3,
        OP_FIND_ALL   = 3'd4,
        OP_TICK       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_POP,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        C_HOLD,
        C_INSERT,
        C_ROTATE,
        C_DROP
    } cell_cmd_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] ttype;
        logic [31:0] ident;
    } payload_t;

    typedef struct packed {
        logic     valid;
        payload_t data;
    } entry_t;

    typedef struct packed {
        cell_cmd_t cmd;
        payload_t  fresh;
    } cell_ctl_t;

endpackage

[src/dstq_cell.sv]
// One slot of the timer chain: holds an entry, inserts, rotates or shifts left.
// Depends on dstq_pkg.
module dstq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  dstq_pkg::cell_ctl_t ctl,
    input  dstq_pkg::entry_t    left_entry,
    input  logic                left_le,
    input  dstq_pkg::entry_t    right_entry,
    input  dstq_pkg::entry_t    head_entry,
    output dstq_pkg::entry_t    entry,
    output logic                le
);

    logic               valid_reg;
    logic               valid_next;
    dstq_pkg::payload_t data_reg;
    dstq_pkg::payload_t data_next;

    assign le          = valid_reg && (data_reg.deadline <= ctl.fresh.deadline);
    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (ctl.cmd)
            dstq_pkg::C_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        valid_next = 1'b1;
                        data_next  = ctl.fresh;
                    end
                    else
                    begin
                        valid_next = left_entry.valid;
                        data_next  = left_entry.data;
                    end
                end
            end
            dstq_pkg::C_ROTATE:
            begin
                // last live slot wraps the head around
                if (valid_reg)
                begin
                    if (!right_entry.valid)
                    begin
                        data_next = head_entry.data;
                    end
                    else
                    begin
                        data_next = right_entry.data;
                    end
                end
            end
            dstq_pkg::C_DROP:
            begin
                valid_next = right_entry.valid;
                data_next  = right_entry.data;
            end
            default:
            begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[src/deadline_sorted_timer_queue_core.sv]
// Deadline-sorted timer queue: a chain of TABLE_DEPTH cells plus a sequencer.
// Add: an insert state, then the result register; busy in the insert state. Search ops rotate the chain once,
// visiting each live entry, then pass a finish state (remove_one/find_one/remove_all/find_all).
// Tick pops one expired head per cycle while hits are below RESULT_CAP, then passes a finish state.
// One item at a time; results come from a register, at most one per cycle, never stalled.
// Reset (async, active low) empties the table at once; no clearing pass.
module deadline_sorted_timer_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [31:0] deadline,
    input  logic [15:0] timer_type,
    input  logic [31:0] timer_id,
    input  logic [31:0] now,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [15:0] out_type,
    output logic [31:0] out_id,
    output logic [31:0] out_deadline,
    output logic        last
);

    localparam int D = dstq_pkg::TABLE_DEPTH;

    dstq_pkg::state_t   state_reg;
    dstq_pkg::state_t   state_next;
    dstq_pkg::op_t      op_reg;
    dstq_pkg::payload_t fresh_reg;
    logic [31:0]        now_reg;
    logic [dstq_pkg::COUNT_W-1:0] count_reg;
    logic [dstq_pkg::COUNT_W-1:0] count_next;
    logic [dstq_pkg::COUNT_W-1:0] rem_reg;
    logic [dstq_pkg::COUNT_W-1:0] rem_next;
    logic [dstq_pkg::HITS_W-1:0]  hits_reg;
    logic [dstq_pkg::HITS_W-1:0]  hits_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    dstq_pkg::payload_t pend_reg;
    dstq_pkg::payload_t pend_next;

    logic               result_valid_reg;
    logic               result_valid_next;
    dstq_pkg::status_t  status_reg;
    dstq_pkg::status_t  status_next;
    dstq_pkg::payload_t res_reg;
    dstq_pkg::payload_t res_next;
    logic               last_reg;
    logic               last_next;

    dstq_pkg::cell_ctl_t ctl;
    dstq_pkg::entry_t    chain [D];
    logic                le_chain [D];
    dstq_pkg::entry_t    head;

    logic accept;
    logic head_match;
    logic head_due;
    logic full;
    logic cap_left;
    logic take;
    logic emit_pend;
    logic count_inc;
    logic count_dec;
    logic hit_inc;
    logic rem_dec;

    assign head       = chain[0];
    assign busy       = (state_reg != dstq_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign head_match = head.valid && (head.data.ttype == fresh_reg.ttype)
                        && (head.data.ident == fresh_reg.ident);
    assign head_due   = head.valid && (head.data.deadline <= now_reg);
    assign full       = (count_reg == dstq_pkg::COUNT_W'(D));
    assign cap_left   = (hits_reg < dstq_pkg::HITS_W'(dstq_pkg::RESULT_CAP));

    for (genvar g = 0; g < D; g++)
    begin : g_cell
        dstq_pkg::entry_t left_e;
        dstq_pkg::entry_t right_e;
        logic             left_l;

        if (g == 0)
        begin : g_first
            assign left_e = '0;
            assign left_l = 1'b1;
        end
        else
        begin : g_inner
            assign left_e = chain[g-1];
            assign left_l = le_chain[g-1];
        end

        if (g == D - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_body
            assign right_e = chain[g+1];
        end

        dstq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_entry  (left_e),
            .left_le     (left_l),
            .right_entry (right_e),
            .head_entry  (head),
            .entry       (chain[g]),
            .le          (le_chain[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dstq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (dstq_pkg::op_t'(operation))
                        dstq_pkg::OP_ADD:        state_next = dstq_pkg::S_INSERT;
                        dstq_pkg::OP_REMOVE_ONE: state_next = dstq_pkg::S_SCAN;
                        dstq_pkg::OP_REMOVE_ALL: state_next = dstq_pkg::S_SCAN;
                        dstq_pkg::OP_FIND_ONE:   state_next = dstq_pkg::S_SCAN;
                        dstq_pkg::OP_FIND_ALL:   state_next = dstq_pkg::S_SCAN;
                        dstq_pkg::OP_TICK:       state_next = dstq_pkg::S_POP;
                        default:                 state_next = dstq_pkg::S_FINISH;
                    endcase
                end
            end
            dstq_pkg::S_INSERT: state_next = dstq_pkg::S_IDLE;
            dstq_pkg::S_SCAN:
            begin
                if (rem_reg == '0)
                begin
                    state_next = dstq_pkg::S_FINISH;
                end
            end
            dstq_pkg::S_POP:
            begin
                if (!(head_due && cap_left))
                begin
                    state_next = dstq_pkg::S_FINISH;
                end
            end
            dstq_pkg::S_FINISH: state_next = dstq_pkg::S_IDLE;
            default:            state_next = dstq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.cmd           = dstq_pkg::C_HOLD;
        ctl.fresh         = fresh_reg;
        take              = 1'b0;
        emit_pend         = 1'b0;
        count_inc         = 1'b0;
        count_dec         = 1'b0;
        hit_inc           = 1'b0;
        rem_dec           = 1'b0;
        result_valid_next = 1'b0;
        status_next       = dstq_pkg::ST_NONE;
        res_next          = '0;
        last_next         = 1'b0;
        case (state_reg)
            dstq_pkg::S_INSERT:
            begin
                result_valid_next = 1'b1;
                last_next         = 1'b1;
                if (full)
                begin
                    status_next = dstq_pkg::ST_FULL;
                end
                else
                begin
                    ctl.cmd     = dstq_pkg::C_INSERT;
                    count_inc   = 1'b1;
                    status_next = dstq_pkg::ST_OK;
                    res_next    = fresh_reg;
                end
            end
            dstq_pkg::S_SCAN:
            begin
                if (rem_reg != '0)
                begin
                    rem_dec = 1'b1;
                    ctl.cmd = dstq_pkg::C_ROTATE;
                    case (op_reg)
                        dstq_pkg::OP_REMOVE_ONE:
                        begin
                            if (head_match && hits_reg == '0)
                            begin
                                ctl.cmd   = dstq_pkg::C_DROP;
                                take      = 1'b1;
                                hit_inc   = 1'b1;
                                count_dec = 1'b1;
                            end
                        end
                        dstq_pkg::OP_FIND_ONE:
                        begin
                            if (head_match && hits_reg == '0)
                            begin
                                take    = 1'b1;
                                hit_inc = 1'b1;
                            end
                        end
                        dstq_pkg::OP_REMOVE_ALL:
                        begin
                            if (head_match)
                            begin
                                ctl.cmd   = dstq_pkg::C_DROP;
                                hit_inc   = cap_left;
                                count_dec = 1'b1;
                            end
                        end
                        dstq_pkg::OP_FIND_ALL:
                        begin
                            if (head_match && cap_left)
                            begin
                                take      = 1'b1;
                                hit_inc   = 1'b1;
                                emit_pend = pend_valid_reg;
                            end
                        end
                        default:
                        begin
                            ctl.cmd = dstq_pkg::C_ROTATE;
                        end
                    endcase
                end
            end
            dstq_pkg::S_POP:
            begin
                if (head_due && cap_left)
                begin
                    ctl.cmd   = dstq_pkg::C_DROP;
                    take      = 1'b1;
                    hit_inc   = 1'b1;
                    count_dec = 1'b1;
                    emit_pend = pend_valid_reg;
                end
            end
            dstq_pkg::S_FINISH:
            begin
                result_valid_next = 1'b1;
                last_next         = 1'b1;
                if (op_reg == dstq_pkg::OP_REMOVE_ALL)
                begin
                    status_next = (hits_reg != '0) ? dstq_pkg::ST_OK : dstq_pkg::ST_NONE;
                end
                else if (pend_valid_reg)
                begin
                    status_next = dstq_pkg::ST_OK;
                    res_next    = pend_reg;
                end
            end
            default:
            begin
                ctl.cmd = dstq_pkg::C_HOLD;
            end
        endcase
        if (emit_pend)
        begin
            result_valid_next = 1'b1;
            status_next       = dstq_pkg::ST_OK;
            res_next          = pend_reg;
            last_next         = 1'b0;
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        rem_next        = rem_reg;
        hits_next       = hits_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (accept)
        begin
            rem_next        = count_reg;
            hits_next       = '0;
            pend_valid_next = 1'b0;
        end
        else
        begin
            if (rem_dec)
            begin
                rem_next = rem_reg - 1'b1;
            end
            if (hit_inc)
            begin
                hits_next = hits_reg + 1'b1;
            end
            if (take)
            begin
                pend_valid_next = 1'b1;
                pend_next       = head.data;
            end
            if (count_inc)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (count_dec)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dstq_pkg::S_IDLE;
            count_reg        <= '0;
            rem_reg          <= '0;
            hits_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            rem_reg          <= rem_next;
            hits_reg         <= hits_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg            <= dstq_pkg::op_t'(operation);
            fresh_reg.deadline <= deadline;
            fresh_reg.ttype    <= timer_type;
            fresh_reg.ident    <= timer_id;
            now_reg           <= now;
        end
        pend_reg   <= pend_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        last_reg   <= last_next;
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign out_type     = res_reg.ttype;
    assign out_id       = res_reg.ident;
    assign out_deadline = res_reg.deadline;
    assign last         = last_reg;

endmodule
